FILE: design/pvc_pkg.sv
package pvc_pkg;

  // Sequencer geometry
  localparam int PC_W = 5;

  // Shared divider: two quotient bits per step
  localparam int DIV_W     = 54;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Fixed-point constants
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [15:0] FULL_DUTY = 16'd32768;
  localparam int          TERM_W    = 47;
  localparam logic [TERM_W-1:0] TERM_SAT = 47'h4000_0000_0000;  // 2^46
  localparam logic [23:0] RAW_SAT   = 24'h80_0000;              // 2^23

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SETPOINT      = 3'd0;
  localparam logic [2:0] REG_OVERALL_GAIN  = 3'd1;
  localparam logic [2:0] REG_INVERSE_TI    = 3'd2;
  localparam logic [2:0] REG_DERIV_TIME    = 3'd3;
  localparam logic [2:0] REG_INT_LIMIT     = 3'd4;
  localparam logic [2:0] REG_OUT_MAX       = 3'd5;
  localparam logic [2:0] REG_OUT_MIN       = 3'd6;
  localparam logic [2:0] REG_DEADBAND      = 3'd7;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_WAIT,
    OP_ERROR,
    OP_THRESH,
    OP_DIV_LOAD_I,
    OP_DIV_STEP,
    OP_INTEGRATE,
    OP_DIV_LOAD_D,
    OP_ITERM_MUL,
    OP_ITERM,
    OP_DTERM_LO,
    OP_DTERM_HI,
    OP_DTERM,
    OP_SUM,
    OP_GAIN_MUL,
    OP_GAIN_LO,
    OP_GAIN_HI,
    OP_FINISH
  } op_t;

  // Stay on the current step while this holds
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_REQ,
    HOLD_OUT_BUSY
  } hold_t;

  // Branch once the step has executed
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_DIV_BUSY
  } jmp_t;

  typedef struct packed {
    op_t              op;
    hold_t            hold;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:    w = ctrl_t'{OP_WAIT,       HOLD_NO_REQ,   JMP_NONE,     5'd0};
      5'd1:    w = ctrl_t'{OP_ERROR,      HOLD_NONE,     JMP_NONE,     5'd0};
      5'd2:    w = ctrl_t'{OP_THRESH,     HOLD_NONE,     JMP_NONE,     5'd0};
      5'd3:    w = ctrl_t'{OP_DIV_LOAD_I, HOLD_NONE,     JMP_NONE,     5'd0};
      5'd4:    w = ctrl_t'{OP_DIV_STEP,   HOLD_NONE,     JMP_DIV_BUSY, 5'd4};
      5'd5:    w = ctrl_t'{OP_INTEGRATE,  HOLD_NONE,     JMP_NONE,     5'd0};
      5'd6:    w = ctrl_t'{OP_DIV_LOAD_D, HOLD_NONE,     JMP_NONE,     5'd0};
      5'd7:    w = ctrl_t'{OP_DIV_STEP,   HOLD_NONE,     JMP_DIV_BUSY, 5'd7};
      5'd8:    w = ctrl_t'{OP_ITERM_MUL,  HOLD_NONE,     JMP_NONE,     5'd0};
      5'd9:    w = ctrl_t'{OP_ITERM,      HOLD_NONE,     JMP_NONE,     5'd0};
      5'd10:   w = ctrl_t'{OP_DTERM_LO,   HOLD_NONE,     JMP_NONE,     5'd0};
      5'd11:   w = ctrl_t'{OP_DTERM_HI,   HOLD_NONE,     JMP_NONE,     5'd0};
      5'd12:   w = ctrl_t'{OP_DTERM,      HOLD_NONE,     JMP_NONE,     5'd0};
      5'd13:   w = ctrl_t'{OP_SUM,        HOLD_NONE,     JMP_NONE,     5'd0};
      5'd14:   w = ctrl_t'{OP_GAIN_MUL,   HOLD_NONE,     JMP_NONE,     5'd0};
      5'd15:   w = ctrl_t'{OP_GAIN_LO,    HOLD_NONE,     JMP_NONE,     5'd0};
      5'd16:   w = ctrl_t'{OP_GAIN_HI,    HOLD_NONE,     JMP_NONE,     5'd0};
      5'd17:   w = ctrl_t'{OP_FINISH,     HOLD_OUT_BUSY, JMP_ALWAYS,   5'd0};
      default: w = ctrl_t'{OP_NOP,        HOLD_NONE,     JMP_ALWAYS,   5'd0};
    endcase
    return w;
  endfunction

endpackage

FILE: design/pid_velocity_controller.sv
// Velocity PID controller with integral anti-windup and a deadband hold. Each request
// carries a signed Q16.16 velocity and the microseconds since the last step (zero counts
// as one); the block returns one Q1.15 duty with held and integral-clamped flags. The
// work is run by an 18-step microcode program over one 32x32 multiplier, a product
// accumulator and a radix-4 restoring divider; the two divisions (error*dt by one
// million, and |delta error|*one million by dt) both run on that divider. A new request
// is taken as soon as the sequencer is back at its first step; the result register holds
// the last duty until taken, and only a second finished result waits for it.
// Configuration may be written only while no request is in progress.
module pid_velocity_controller (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [30:0] cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [31:0] measured_velocity, [51:32] elapsed_us
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] duty, [16] held, [17] integral_clamped
);

  // Configuration registers
  logic [30:0] setpoint;
  logic [30:0] overall_gain;
  logic [30:0] inverse_ti;
  logic [30:0] derivative_time;
  logic [30:0] integral_limit;
  logic [15:0] out_max;
  logic [15:0] out_min;
  logic [15:0] deadband_ratio;

  // Controller state
  logic [31:0] integ;
  logic [31:0] prev_err;
  logic [15:0] prev_out;

  // Sequencer
  logic [pvc_pkg::PC_W-1:0] pc;
  logic [pvc_pkg::PC_W-1:0] pc_next;
  pvc_pkg::ctrl_t           cw;
  logic                     stall;

  // Datapath registers
  logic [31:0] vel_mag;
  logic [19:0] elapsed;
  logic [31:0] err;
  logic [30:0] thr;
  logic        diff_neg;
  logic [31:0] diff_mag;
  logic        int_clamp;
  logic [51:0] dmag;
  logic [pvc_pkg::TERM_W-1:0] iterm;
  logic [pvc_pkg::TERM_W-1:0] dterm;
  logic [47:0] s_pos;
  logic [63:0] mprod;
  logic [83:0] acc;

  // Divider
  logic [pvc_pkg::DIV_W-1:0]     div_q;
  logic [19:0]                   div_rem;
  logic [19:0]                   div_den;
  logic [pvc_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          div_busy;

  // Result register
  logic        out_valid;
  logic [15:0] out_duty;
  logic        out_held;
  logic        out_clamp;

  // Combinational helpers
  logic [31:0]        vel_raw;
  logic [31:0]        vel_mag_in;
  logic [19:0]        elapsed_in;
  logic [31:0]        err_mag;
  logic [32:0]        diff_full;
  logic [32:0]        diff_abs;
  logic [31:0]        integ_mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [20:0]        r1;
  logic [19:0]        r1s;
  logic               q1;
  logic [20:0]        r2;
  logic [19:0]        r2s;
  logic               q2;
  logic signed [33:0] inc_s;
  logic signed [33:0] sum34;
  logic signed [33:0] lim34;
  logic signed [33:0] nlim34;
  logic signed [48:0] iterm_s;
  logic signed [48:0] dterm_s;
  logic signed [48:0] s_sum;
  logic [23:0]        cand;
  logic [15:0]        outv;
  logic               hold_hit;

  // Control word fetch and step sequencing
  assign cw       = pvc_pkg::ucode(pc);
  assign div_busy = (div_cnt != pvc_pkg::DIV_LAST);
  assign s_tready = (cw.op == pvc_pkg::OP_WAIT);

  always_comb begin
    unique case (cw.hold)
      pvc_pkg::HOLD_NO_REQ:   stall = !s_tvalid;
      pvc_pkg::HOLD_OUT_BUSY: stall = out_valid && !m_tready;
      default:                stall = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else begin
      unique case (cw.jmp)
        pvc_pkg::JMP_ALWAYS:   pc_next = cw.target;
        pvc_pkg::JMP_DIV_BUSY: pc_next = div_busy ? cw.target : pc + 1'b1;
        default:               pc_next = pc + 1'b1;
      endcase
    end
  end

  // Input decode and magnitudes
  assign vel_raw    = s_tdata[31:0];
  assign vel_mag_in = vel_raw[31] ? (~vel_raw + 32'd1) : vel_raw;
  assign elapsed_in = (s_tdata[51:32] == 20'd0) ? 20'd1 : s_tdata[51:32];
  assign err_mag    = err[31] ? (~err + 32'd1) : err;
  assign diff_full  = {err[31], err} - {prev_err[31], prev_err};
  assign diff_abs   = diff_full[32] ? (~diff_full + 33'd1) : diff_full;
  assign integ_mag  = integ[31] ? (~integ + 32'd1) : integ;

  // Shared multiplier operand selection
  always_comb begin
    unique case (cw.op)
      pvc_pkg::OP_ERROR: begin
        mul_a = {1'b0, setpoint};
        mul_b = {16'd0, deadband_ratio};
      end
      pvc_pkg::OP_THRESH: begin
        mul_a = err_mag;
        mul_b = {12'd0, elapsed};
      end
      pvc_pkg::OP_INTEGRATE: begin
        mul_a = diff_mag;
        mul_b = {12'd0, pvc_pkg::US_PER_S};
      end
      pvc_pkg::OP_ITERM_MUL: begin
        mul_a = integ_mag;
        mul_b = {1'b0, inverse_ti};
      end
      pvc_pkg::OP_ITERM: begin
        mul_a = dmag[31:0];
        mul_b = {1'b0, derivative_time};
      end
      pvc_pkg::OP_DTERM_LO: begin
        mul_a = {12'd0, dmag[51:32]};
        mul_b = {1'b0, derivative_time};
      end
      pvc_pkg::OP_GAIN_MUL: begin
        mul_a = s_pos[31:0];
        mul_b = {1'b0, overall_gain};
      end
      pvc_pkg::OP_GAIN_LO: begin
        mul_a = {16'd0, s_pos[47:32]};
        mul_b = {1'b0, overall_gain};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Radix-4 restoring divide step
  always_comb begin
    r1  = {div_rem, div_q[pvc_pkg::DIV_W-1]};
    q1  = (r1 >= {1'b0, div_den});
    r1s = q1 ? 20'(r1 - {1'b0, div_den}) : r1[19:0];
    r2  = {r1s, div_q[pvc_pkg::DIV_W-2]};
    q2  = (r2 >= {1'b0, div_den});
    r2s = q2 ? 20'(r2 - {1'b0, div_den}) : r2[19:0];
  end

  // Integral update with windup clamp
  always_comb begin
    inc_s  = err[31] ? -$signed({2'b00, div_q[31:0]}) : $signed({2'b00, div_q[31:0]});
    sum34  = $signed({{2{integ[31]}}, integ}) + inc_s;
    lim34  = $signed({3'b000, integral_limit});
    nlim34 = -lim34;
  end

  // Term sum
  always_comb begin
    iterm_s = integ[31] ? -$signed({2'b00, iterm}) : $signed({2'b00, iterm});
    dterm_s = diff_neg  ? -$signed({2'b00, dterm}) : $signed({2'b00, dterm});
    s_sum   = $signed({{17{err[31]}}, err}) + iterm_s + dterm_s;
  end

  // Gain product saturation, duty clamps and deadband hold
  always_comb begin
    cand = (acc[83:17] > {43'd0, pvc_pkg::RAW_SAT}) ? pvc_pkg::RAW_SAT : acc[40:17];
    if (cand > {8'd0, out_max}) begin
      outv = out_max;
    end else if (cand < {8'd0, out_min}) begin
      outv = out_min;
    end else begin
      outv = cand[15:0];
    end
    hold_hit = (err_mag <= {1'b0, thr});
    if (hold_hit) begin
      outv = prev_out;
    end
  end

  // Control, configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= '0;
      out_valid       <= 1'b0;
      setpoint        <= 31'd0;
      overall_gain    <= 31'd65536;
      inverse_ti      <= 31'd0;
      derivative_time <= 31'd0;
      integral_limit  <= 31'h7FFF_FFFF;
      out_max         <= pvc_pkg::FULL_DUTY;
      out_min         <= 16'd0;
      deadband_ratio  <= 16'd0;
      integ           <= 32'd0;
      prev_err        <= 32'd0;
      prev_out        <= 16'd0;
    end else begin
      pc <= pc_next;

      if (cfg_we) begin
        case (cfg_addr)
          pvc_pkg::REG_SETPOINT:     setpoint        <= cfg_wdata;
          pvc_pkg::REG_OVERALL_GAIN: overall_gain    <= cfg_wdata;
          pvc_pkg::REG_INVERSE_TI:   inverse_ti      <= cfg_wdata;
          pvc_pkg::REG_DERIV_TIME:   derivative_time <= cfg_wdata;
          pvc_pkg::REG_INT_LIMIT:    integral_limit  <= cfg_wdata;
          pvc_pkg::REG_OUT_MAX:      out_max         <= cfg_wdata[15:0];
          pvc_pkg::REG_OUT_MIN:      out_min         <= cfg_wdata[15:0];
          pvc_pkg::REG_DEADBAND:     deadband_ratio  <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // integral commits as soon as the increment is known
      if (cw.op == pvc_pkg::OP_INTEGRATE) begin
        if (sum34 > lim34) begin
          integ <= lim34[31:0];
        end else if (sum34 < nlim34) begin
          integ <= nlim34[31:0];
        end else begin
          integ <= sum34[31:0];
        end
      end

      // result handshake: a finish step always wins over a take
      if (cw.op == pvc_pkg::OP_FINISH && !stall) begin
        out_valid <= 1'b1;
        prev_err  <= err;
        prev_out  <= outv;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    mprod <= mul_a * mul_b;

    unique case (cw.op)
      pvc_pkg::OP_WAIT: begin
        if (!stall) begin
          vel_mag <= vel_mag_in;
          elapsed <= elapsed_in;
        end
      end
      pvc_pkg::OP_ERROR: begin
        err <= 32'({1'b0, 1'b0, setpoint} - {1'b0, vel_mag});
      end
      pvc_pkg::OP_THRESH: begin
        thr      <= mprod[46:16];
        diff_neg <= diff_full[32];
        diff_mag <= diff_abs[31:0];
      end
      pvc_pkg::OP_DIV_LOAD_I: begin
        div_q   <= mprod[pvc_pkg::DIV_W-1:0];
        div_den <= pvc_pkg::US_PER_S;
        div_rem <= 20'd0;
        div_cnt <= '0;
      end
      pvc_pkg::OP_DIV_STEP: begin
        div_q   <= {div_q[pvc_pkg::DIV_W-3:0], q1, q2};
        div_rem <= r2s;
        div_cnt <= div_cnt + 1'b1;
      end
      pvc_pkg::OP_INTEGRATE: begin
        int_clamp <= (sum34 > lim34) || (sum34 < nlim34);
      end
      pvc_pkg::OP_DIV_LOAD_D: begin
        div_q   <= mprod[pvc_pkg::DIV_W-1:0];
        div_den <= elapsed;
        div_rem <= 20'd0;
        div_cnt <= '0;
      end
      pvc_pkg::OP_ITERM_MUL: begin
        dmag <= div_q[51:0];
      end
      pvc_pkg::OP_ITERM: begin
        iterm <= (mprod[63:16] > {1'b0, pvc_pkg::TERM_SAT}) ? pvc_pkg::TERM_SAT
                                                             : mprod[62:16];
      end
      pvc_pkg::OP_DTERM_LO, pvc_pkg::OP_GAIN_LO: begin
        acc <= {20'd0, mprod};
      end
      pvc_pkg::OP_DTERM_HI, pvc_pkg::OP_GAIN_HI: begin
        acc <= acc + {mprod[51:0], 32'd0};
      end
      pvc_pkg::OP_DTERM: begin
        dterm <= (acc[83:16] > {21'd0, pvc_pkg::TERM_SAT}) ? pvc_pkg::TERM_SAT
                                                            : acc[62:16];
      end
      pvc_pkg::OP_SUM: begin
        s_pos <= (!s_sum[48] && (s_sum != '0)) ? s_sum[47:0] : 48'd0;
      end
      pvc_pkg::OP_FINISH: begin
        if (!stall) begin
          out_duty  <= (outv > pvc_pkg::FULL_DUTY) ? pvc_pkg::FULL_DUTY : outv;
          out_held  <= hold_hit;
          out_clamp <= int_clamp;
        end
      end
      default: ;
    endcase
  end

  // Result stream
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_clamp, out_held, out_duty};

`ifndef SYNTHESIS
  // the presented duty is always the stored output after the full-duty clamp
  a_duty_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] == ((prev_out > pvc_pkg::FULL_DUTY) ? pvc_pkg::FULL_DUTY
                                                                     : prev_out)))
    else $error("duty does not match stored previous output");

  // one request in flight: the sequencer leaves the wait step on acceptance
  a_single_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted twice in a row");

  // divider never runs past its last step
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (cw.op == pvc_pkg::OP_DIV_STEP) |-> (div_cnt <= pvc_pkg::DIV_LAST))
    else $error("divider step counter overrun");

  // a finish step that stalls keeps the previous result untouched
  a_finish_stall: assert property (@(posedge clk) disable iff (rst)
    (cw.op == pvc_pkg::OP_FINISH && stall) |=> $stable(m_tdata))
    else $error("pending result changed while stalled");
`endif

endmodule

FILE: tb/tb_pid_velocity_controller.sv
`timescale 1ns / 100ps

module tb_pid_velocity_controller;
  import pvc_pkg::*;

  // One expected result of a control step
  typedef struct packed {
    logic [15:0] duty;
    logic        held;
    logic        clamped;
  } duty_result_t;

  // Controller model plus the queue of duties still owed by the block
  class duty_scoreboard;
    longint setpoint, overall_gain, inverse_ti, derivative_time, integral_limit;
    longint out_max, out_min, deadband_ratio;
    longint integral_sum, previous_error, previous_output;
    duty_result_t expected_duty_q[$];
    int errors;

    function new();
      setpoint        = 0;
      overall_gain    = 65536;
      inverse_ti      = 0;
      derivative_time = 0;
      integral_limit  = 64'd2147483647;
      out_max         = longint'(FULL_DUTY);
      out_min         = 0;
      deadband_ratio  = 0;
      integral_sum    = 0;
      previous_error  = 0;
      previous_output = 0;
      errors          = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        REG_SETPOINT:     setpoint        = longint'(val);
        REG_OVERALL_GAIN: overall_gain    = longint'(val);
        REG_INVERSE_TI:   inverse_ti      = longint'(val);
        REG_DERIV_TIME:   derivative_time = longint'(val);
        REG_INT_LIMIT:    integral_limit  = longint'(val);
        REG_OUT_MAX:      out_max         = longint'(val[15:0]);
        REG_OUT_MIN:      out_min         = longint'(val[15:0]);
        REG_DEADBAND:     deadband_ratio  = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_duty_q.size();
    endfunction

    function longint magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // Q16.16 product of two magnitudes, saturated at 2^46
    function longint q16_product(longint a, longint b);
      longint sat, r;
      sat = longint'(TERM_SAT);
      if (b != 0 && a > (sat << 16) / b) return sat;
      r = (a * b) >> 16;
      return (r > sat) ? sat : r;
    endfunction

    // One control step: updates the state and queues the duty it yields
    function void note_request(logic [31:0] vel, logic [19:0] elapsed);
      longint v, dt, err, acc, lim, diff, dmag, iterm, dterm, s, cand, outv, thr;
      duty_result_t r;
      v   = longint'($signed(vel));
      dt  = (elapsed == 0) ? 1 : longint'(elapsed);
      err = setpoint - magnitude(v);
      r.clamped = 1'b0;
      r.held    = 1'b0;

      // integral with anti-windup
      acc = integral_sum + (err * dt) / longint'(US_PER_S);
      lim = integral_limit;
      if (acc > lim) begin
        acc = lim;
        r.clamped = 1'b1;
      end
      if (acc < -lim) begin
        acc = -lim;
        r.clamped = 1'b1;
      end
      integral_sum = acc;

      diff = err - previous_error;
      dmag = (magnitude(diff) * longint'(US_PER_S)) / dt;

      iterm = q16_product(magnitude(acc), inverse_ti);
      if (acc < 0) iterm = -iterm;
      dterm = q16_product(dmag, derivative_time);
      if (diff < 0) dterm = -dterm;
      s = err + iterm + dterm;

      // gain stage, Q16.16 times Q16.16 down to Q1.15
      if (s <= 0) begin
        cand = 0;
      end else if (overall_gain != 0 && s > (longint'(1) << 40) / overall_gain) begin
        cand = longint'(RAW_SAT);
      end else begin
        cand = (overall_gain * s) >> 17;
      end

      if (cand > out_max) outv = out_max;
      else if (cand < out_min) outv = out_min;
      else outv = cand;

      // deadband hold keeps the previous duty
      thr = (setpoint * deadband_ratio) >> 16;
      if (magnitude(err) <= thr) begin
        outv   = previous_output;
        r.held = 1'b1;
      end

      previous_error  = err;
      previous_output = outv & 64'hFFFF;
      r.duty = (outv > longint'(FULL_DUTY)) ? FULL_DUTY : outv[15:0];
      expected_duty_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      duty_result_t exp_r;
      if (expected_duty_q.size() == 0) begin
        $error("result 0x%h with no request outstanding", data);
        errors++;
        return;
      end
      exp_r = expected_duty_q.pop_front();
      if (data[15:0] !== exp_r.duty) begin
        $error("duty: expected %0d, actual %0d", exp_r.duty, data[15:0]);
        errors++;
      end
      if (data[16] !== exp_r.held) begin
        $error("held: expected %0b, actual %0b", exp_r.held, data[16]);
        errors++;
      end
      if (data[17] !== exp_r.clamped) begin
        $error("integral_clamped: expected %0b, actual %0b", exp_r.clamped, data[17]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = '0;
  logic [30:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;

  duty_scoreboard sb = new();

  // no random idling on either side when set
  bit quiet        = 1'b0;
  // asks the result side for one long hold-off
  bit hold_off_req = 1'b0;

  pid_velocity_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Random value with a random number of low bits kept
  function automatic longint rand_bits(int w);
    longint r;
    int n;
    r = {$urandom, $urandom};
    n = $urandom_range(0, w);
    if (n == 0) return 0;
    return r & ((longint'(1) << n) - 1);
  endfunction

  // Configuration write; the enable stays high across back-to-back writes
  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[30:0];
    @(posedge clk);
    sb.set_reg(idx, val[30:0]);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and wait for it to be taken
  task automatic send_req(logic [31:0] vel, logic [19:0] el);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, el, vel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(vel, el);
  endtask

  // Stop offering and wait until every duty has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // New settings for one random phase: max, zero, tuned or random
  task automatic set_phase(int p);
    longint vals[8];
    longint sp;
    if (p == 0) begin
      vals[REG_SETPOINT]     = 64'h7FFF_FFFF;
      vals[REG_OVERALL_GAIN] = 64'h7FFF_FFFF;
      vals[REG_INVERSE_TI]   = 64'h7FFF_FFFF;
      vals[REG_DERIV_TIME]   = 64'h7FFF_FFFF;
      vals[REG_INT_LIMIT]    = 64'h7FFF_FFFF;
      vals[REG_OUT_MAX]      = 64'hFFFF;
      vals[REG_OUT_MIN]      = 0;
      vals[REG_DEADBAND]     = 64'hFFFF;
    end else if (p == 1) begin
      foreach (vals[r]) vals[r] = 0;
      vals[REG_OUT_MIN] = 64'hFFFF;
    end else if (p % 2 == 0) begin
      // plausible tuning: duty rarely saturates
      sp = longint'($urandom_range(1, 3000)) << 16;
      vals[REG_SETPOINT]     = sp;
      vals[REG_OVERALL_GAIN] = $urandom_range(1, (longint'(1) << 32) / sp);
      vals[REG_INVERSE_TI]   = rand_bits(20);
      vals[REG_DERIV_TIME]   = rand_bits(14);
      vals[REG_INT_LIMIT]    = rand_bits(31);
      vals[REG_OUT_MAX]      = $urandom_range(0, 32768);
      vals[REG_OUT_MIN]      = $urandom_range(0, vals[REG_OUT_MAX]);
      vals[REG_DEADBAND]     = rand_bits(12);
    end else begin
      vals[REG_SETPOINT]     = rand_bits(31);
      vals[REG_OVERALL_GAIN] = rand_bits(31);
      vals[REG_INVERSE_TI]   = rand_bits(31);
      vals[REG_DERIV_TIME]   = rand_bits(31);
      vals[REG_INT_LIMIT]    = rand_bits(31);
      vals[REG_OUT_MAX]      = rand_bits(16);
      vals[REG_OUT_MIN]      = rand_bits(16);
      vals[REG_DEADBAND]     = rand_bits(16);
    end
    for (int r = 0; r < 8; r++) write_reg(3'(r), vals[r]);
    end_cfg();
  endtask

  // Random requests, most of them near the setpoint
  task automatic run_phase(int count);
    logic [31:0] vel;
    logic [19:0] el;
    longint base, off;
    int mode;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        off = rand_bits(20);
        if ($urandom_range(0, 1)) off = -off;
        base = sb.setpoint + off;
        if ($urandom_range(0, 1)) base = -base;
        vel = base[31:0];
      end else if (mode <= 7) begin
        vel = $urandom;
      end else if (mode == 8) begin
        case ($urandom_range(0, 3))
          0: vel = 32'h8000_0000;
          1: vel = 32'h7FFF_FFFF;
          2: vel = 32'hFFFF_FFFF;
          default: vel = 32'h0000_0001;
        endcase
      end else begin
        vel = '0;
      end

      mode = $urandom_range(0, 9);
      if (mode <= 5) el = $urandom_range(500, 1500);
      else if (mode == 6) el = '0;
      else if (mode == 7) el = 20'hFFFFF;
      else if (mode == 8) el = $urandom_range(0, 20'hFFFFF);
      else el = rand_bits(20);

      send_req(vel, el);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Result side: check each taken result, then choose the next ready level
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_off_req) begin
        stall_left   = 1000;
        hold_off_req = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero error is inside a zero deadband
    send_req(32'h0, 20'h0);
    send_req(32'h8000_0000, 20'hFFFFF);
    send_req(32'h7FFF_FFFF, 20'h1);
    drain();

    // moderate tuning, integral driven into its bound
    write_reg(REG_SETPOINT, 100 << 16);
    write_reg(REG_OVERALL_GAIN, 655);
    write_reg(REG_INVERSE_TI, 1 << 16);
    write_reg(REG_DERIV_TIME, 655);
    write_reg(REG_INT_LIMIT, 50 << 16);
    write_reg(REG_OUT_MAX, 30000);
    write_reg(REG_OUT_MIN, 1000);
    write_reg(REG_DEADBAND, 655);
    end_cfg();
    send_req(32'(100 << 16), 20'd1000);
    send_req(-32'(100 << 16), 20'd0);
    repeat (3) send_req(32'h0, 20'hFFFFF);
    send_req(32'(60 << 16), 20'd1000);
    drain();

    // limit lowered below the integral already held
    write_reg(REG_INT_LIMIT, 10 << 16);
    end_cfg();
    send_req(32'(100 << 16), 20'd1000);
    send_req(-32'(90 << 16), 20'd500);
    drain();

    // lower clamp above upper clamp
    write_reg(REG_OUT_MAX, 2000);
    write_reg(REG_OUT_MIN, 5000);
    end_cfg();
    send_req(32'h0, 20'd1000);
    send_req(32'(200 << 16), 20'd1000);
    drain();

    // clamps beyond full duty, every gain at its top
    write_reg(REG_OUT_MAX, 65535);
    write_reg(REG_OUT_MIN, 40000);
    write_reg(REG_SETPOINT, 64'h7FFF_FFFF);
    write_reg(REG_OVERALL_GAIN, 64'h7FFF_FFFF);
    write_reg(REG_INVERSE_TI, 64'h7FFF_FFFF);
    write_reg(REG_DERIV_TIME, 64'h7FFF_FFFF);
    write_reg(REG_DEADBAND, 0);
    end_cfg();
    send_req(32'h0, 20'hFFFFF);
    send_req(32'h8000_0000, 20'h0);
    send_req(32'h1, 20'h1);
    drain();
    // hold re-issues a stored duty above full scale
    write_reg(REG_DEADBAND, 65535);
    end_cfg();
    send_req(32'd12345, 20'd1000);
    drain();

    // random phases; one long result hold-off, quiet at the end
    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1'b1;
      set_phase(p);
      if (p == 2) hold_off_req = 1'b1;
      run_phase(210);
      drain();
    end

    repeat (80) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pvc_pkg.sv
design/pid_velocity_controller.sv
tb/tb_pid_velocity_controller.sv
